FILE: hw/rtl/rmd_pkg.sv
// ----------------------------------------------------------------------------
// rmd_pkg - shared types and helpers of the register motor drive
// Request payload types, the duty width and the duty clamp function.
// ----------------------------------------------------------------------------
`default_nettype none

package rmd_pkg;

  localparam int DUTY_BITS = 8;
  localparam logic signed [16:0] DUTY_MAX = 17'((1 << DUTY_BITS) - 1);

  localparam int NUM_WORDS = 3;

  // Target selectors carried by the opening byte of a transaction
  localparam logic [7:0] SEL_MOTOR1 = 8'd1;
  localparam logic [7:0] SEL_MOTOR2 = 8'd2;
  localparam logic [7:0] SEL_TAIL   = 8'd3;
  localparam logic [7:0] SEL_UART   = 8'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       uart_valid;
    logic [7:0] uart_data;
    logic       drive_update;
    logic [7:0] motor1_duty;
    logic [7:0] motor2_duty;
    logic [7:0] tail_forward_duty;
    logic [7:0] tail_reverse_duty;
  } out_item_t;

  typedef logic [15:0] word_t;
  typedef word_t [NUM_WORDS-1:0] word_bank_t;

  typedef struct packed {
    logic [7:0] motor1;
    logic [7:0] motor2;
    logic [7:0] tail_fwd;
    logic [7:0] tail_rev;
  } duties_t;

  // Result of one write step, passed from the register file to the top
  typedef struct packed {
    logic       uart_valid;
    logic [7:0] uart_data;
    logic       drive_update;
  } step_t;

  function automatic logic [7:0] clamp_duty(input logic signed [16:0] v);
    logic [7:0] r;
    if (v < 17'sd0) begin
      r = 8'd0;
    end else if (v > DUTY_MAX) begin
      r = DUTY_MAX[7:0];
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rmd_in_if.sv
// ----------------------------------------------------------------------------
// rmd_in_if - received byte channel
// Valid/ready channel that carries one received bus byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmd_in_if;
  logic             valid;
  logic             ready;
  rmd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rmd_out_if.sv
// ----------------------------------------------------------------------------
// rmd_out_if - result channel
// Valid/ready channel that carries the UART byte and drive duties.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmd_out_if;
  logic              valid;
  logic              ready;
  rmd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rmd_regfile.sv
// ----------------------------------------------------------------------------
// rmd_regfile - transaction decoder and motor word registers
// Tracks pointer, target and byte phase, writes the 16-bit motor words.
// ----------------------------------------------------------------------------
`default_nettype none

module rmd_regfile (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                advance,
  input  wire rmd_pkg::in_item_t   item,
  output rmd_pkg::word_bank_t      words_next,
  output rmd_pkg::step_t           step
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_MOTOR   = 2'd1;
  localparam logic [1:0] MODE_UART    = 2'd2;
  localparam logic [1:0] MODE_DISCARD = 2'd3;

  logic [2:0]          reg_pointer;
  logic [2:0]          reg_pointer_next;
  logic [1:0]          target_mode;
  logic [1:0]          target_mode_next;
  logic                high_phase;
  logic                high_phase_next;
  rmd_pkg::word_bank_t words;

  logic [1:0] idx;
  logic [1:0] slot;

  always_comb begin
    reg_pointer_next = reg_pointer;
    target_mode_next = target_mode;
    high_phase_next  = high_phase;
    words_next       = words;
    step             = '0;
    idx              = 2'd1;
    slot             = 2'd0;

    if (item.first_byte) begin
      high_phase_next = 1'b0;
      if (item.last_byte) begin
        reg_pointer_next = 3'd0;
        target_mode_next = MODE_IDLE;
      end else begin
        reg_pointer_next = item.rx_byte[2:0];
        if (item.rx_byte >= rmd_pkg::SEL_MOTOR1 && item.rx_byte <= rmd_pkg::SEL_TAIL) begin
          target_mode_next = MODE_MOTOR;
        end else if (item.rx_byte == rmd_pkg::SEL_UART) begin
          target_mode_next = MODE_UART;
        end else begin
          target_mode_next = MODE_DISCARD;
        end
      end
    end else begin
      unique case (target_mode)
        MODE_MOTOR: begin
          // clamp the pointer into the word range
          if (reg_pointer == 3'd0) begin
            idx = 2'd1;
          end else if (reg_pointer > 3'd3) begin
            idx = 2'd3;
          end else begin
            idx = reg_pointer[1:0];
          end
          slot = idx - 2'd1;
          if (!high_phase) begin
            words_next[slot] = {8'h00, item.rx_byte};
            high_phase_next  = 1'b1;
          end else begin
            words_next[slot][15:8] = item.rx_byte;
            high_phase_next        = 1'b0;
            if (idx < 2'd3) begin
              idx = idx + 2'd1;
            end
          end
          reg_pointer_next  = {1'b0, idx};
          step.drive_update = item.last_byte;
        end
        MODE_UART: begin
          step.uart_valid = 1'b1;
          step.uart_data  = item.rx_byte;
        end
        MODE_IDLE, MODE_DISCARD: begin
        end
        default: begin
        end
      endcase
      if (item.last_byte) begin
        target_mode_next = MODE_IDLE;
        high_phase_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_pointer <= 3'd0;
      target_mode <= MODE_IDLE;
      high_phase  <= 1'b0;
      words       <= '0;
    end else if (advance) begin
      reg_pointer <= reg_pointer_next;
      target_mode <= target_mode_next;
      high_phase  <= high_phase_next;
      words       <= words_next;
    end
  end

  // Motor mode always has a selector of one to three behind it
  assert property (@(posedge clk) disable iff (rst)
    target_mode == MODE_MOTOR |-> reg_pointer != 3'd0 && reg_pointer <= 3'd3)
    else $error("motor target with pointer out of range");

  // High phase exists only inside a motor transaction
  assert property (@(posedge clk) disable iff (rst)
    high_phase |-> target_mode == MODE_MOTOR)
    else $error("high phase outside motor transaction");

  assert property (@(posedge clk) disable iff (rst)
    step.uart_valid |-> !step.drive_update)
    else $error("uart byte and duty refresh from one request");

endmodule

`default_nettype wire

FILE: hw/rtl/rmd_duty.sv
// ----------------------------------------------------------------------------
// rmd_duty - duty computation
// Clamps the two main motor words and splits the tail word by sign.
// ----------------------------------------------------------------------------
`default_nettype none

module rmd_duty (
  input  wire rmd_pkg::word_bank_t words,
  output rmd_pkg::duties_t         duties
);

  logic signed [16:0] m1;
  logic signed [16:0] m2;
  logic signed [16:0] tail;
  logic signed [16:0] tail_neg;

  assign m1       = 17'(signed'(words[0]));
  assign m2       = 17'(signed'(words[1]));
  assign tail     = 17'(signed'(words[2]));
  assign tail_neg = -tail;

  always_comb begin
    duties.motor1   = rmd_pkg::clamp_duty(m1);
    duties.motor2   = rmd_pkg::clamp_duty(m2);
    duties.tail_fwd = 8'd0;
    duties.tail_rev = 8'd0;
    if (tail > 17'sd0) begin
      duties.tail_fwd = rmd_pkg::clamp_duty(tail);
    end else if (tail < 17'sd0) begin
      duties.tail_rev = rmd_pkg::clamp_duty(tail_neg);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_register_motor_drive.sv
// ----------------------------------------------------------------------------
// i2c_register_motor_drive - register-mapped motor drive, byte write port
// Decodes bus write transactions into motor words, UART bytes and duties.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one received bus byte per request, flagged first/last of its
//            write transaction. The first byte of a multi-byte transaction
//            selects a target: 1..3 motor words, 4 UART, others discarded.
//   result : exactly one request per accepted byte, carrying the UART byte
//            (if any), the refresh flag and the current four drive duties.
// Timing:
//   A byte is held in the input register; the state update and
//   duty clamp run between it and the result register, which raises
//   result valid when the held byte advances into it. One byte per cycle
//   is sustained while result.ready stays high.
// Reset:
//   rst clears pointer, target, phase, motor words and duties to zero and
//   empties both stages.
// Backpressure:
//   While result.ready is low the result holds; one more byte can wait in
//   the input register, after which item.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_motor_drive (
  input  wire logic clk,
  input  wire logic rst,
  rmd_in_if.sink    item,
  rmd_out_if.source result
);

  logic              s1_valid;
  rmd_pkg::in_item_t s1_item;
  logic              advance;

  rmd_pkg::word_bank_t words_next;
  rmd_pkg::step_t      step;
  rmd_pkg::duties_t    duties_new;

  assign advance    = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item <= item.data;
    end
  end

  rmd_regfile u_regfile (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (s1_item),
    .words_next (words_next),
    .step       (step)
  );

  rmd_duty u_duty (
    .words  (words_next),
    .duties (duties_new)
  );

  // Duty fields of the result register double as the drive duty state
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      result.data  <= '0;
    end else if (advance) begin
      result.valid             <= 1'b1;
      result.data.uart_valid   <= step.uart_valid;
      result.data.uart_data    <= step.uart_data;
      result.data.drive_update <= step.drive_update;
      if (step.drive_update) begin
        result.data.motor1_duty       <= duties_new.motor1;
        result.data.motor2_duty       <= duties_new.motor2;
        result.data.tail_forward_duty <= duties_new.tail_fwd;
        result.data.tail_reverse_duty <= duties_new.tail_rev;
      end
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !(result.data.tail_forward_duty != 8'd0 && result.data.tail_reverse_duty != 8'd0))
    else $error("tail driven both ways");

  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.uart_valid |-> result.data.uart_data == 8'd0)
    else $error("uart data without uart valid");

  assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s1_valid))
    else $error("result without a held byte");

  assert property (@(posedge clk) disable iff (rst)
    !result.data.drive_update |=> $stable(result.data.motor1_duty) || $past(advance))
    else $error("duty changed without refresh");

endmodule

`default_nettype wire
